// ===== rtl/crs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 5;
  localparam int LAYER_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LAYER   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_CULLED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLIPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VISIBLE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_BOTTOM = 2'd3;

  localparam int ROOT_LEFT_RST   = 0;
  localparam int ROOT_TOP_RST    = 0;
  localparam int ROOT_RIGHT_RST  = 30720;
  localparam int ROOT_BOTTOM_RST = 17280;

  typedef struct packed {
    logic take_item;
    logic exec_op;
    logic scan_run;
    logic meet_op;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             scan_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/clip_rect_stack.sv =====
// clip rect stack: push, pop and clear pass through an execute state, then load the result beat;
// resolve adds a meet state before the load; layer resolve scans the stack, one stack entry read
// per cycle, then meets and loads. one item in flight; the next item is accepted the cycle after
// the result is registered
// reset (synchronous): stack empty, root clip at its default, stack ram contents undefined,
// no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module clip_rect_stack #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0]          cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [crs_pkg::CMD_W-1:0]      cmd,
  input  wire logic signed [COORD_BITS-1:0]   rect_left,
  input  wire logic signed [COORD_BITS-1:0]   rect_top,
  input  wire logic signed [COORD_BITS-1:0]   rect_right,
  input  wire logic signed [COORD_BITS-1:0]   rect_bottom,
  input  wire logic [crs_pkg::LAYER_W-1:0]    layer_id,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [COORD_BITS-1:0]        bounds_left,
  output logic signed [COORD_BITS-1:0]        bounds_top,
  output logic signed [COORD_BITS-1:0]        bounds_right,
  output logic signed [COORD_BITS-1:0]        bounds_bottom,
  output logic signed [COORD_BITS-1:0]        clip_left,
  output logic signed [COORD_BITS-1:0]        clip_top,
  output logic signed [COORD_BITS-1:0]        clip_right,
  output logic signed [COORD_BITS-1:0]        clip_bottom,
  output logic [crs_pkg::DEPTH_W-1:0]         clip_depth,
  output logic [crs_pkg::STATUS_W-1:0]        status
);
  import crs_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  crs_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_right    (rect_right),
    .rect_bottom   (rect_bottom),
    .layer_id      (layer_id),
    .bounds_left   (bounds_left),
    .bounds_top    (bounds_top),
    .bounds_right  (bounds_right),
    .bounds_bottom (bounds_bottom),
    .clip_left     (clip_left),
    .clip_top      (clip_top),
    .clip_right    (clip_right),
    .clip_bottom   (clip_bottom),
    .clip_depth    (clip_depth),
    .status        (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !out_valid || !out_stall)
    else $error("result register overwritten while a beat is pending");

  a_scan_layer_only: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_run |-> stat.item_cmd == CMD_LAYER)
    else $error("stack scan outside a layer resolve");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> clip_depth == DEPTH_W'(STACK_DEPTH))
    else $error("overflow reported with stack not full");

endmodule

`default_nettype wire

// ===== rtl/crs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crs_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/crs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [crs_pkg::CMD_W-1:0] cmd,
  input  wire logic                      out_stall,
  input  wire crs_pkg::stat_t            stat,
  output logic                           in_stall,
  output logic                           out_valid,
  output crs_pkg::ctl_t                  ctl
);
  import crs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MEET = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    ctl           = '0;
    ctl.take_item = (state == S_IDLE) && in_valid;
    ctl.exec_op   = (state == S_EXEC);
    ctl.scan_run  = (state == S_SCAN) && !stat.scan_done;
    ctl.meet_op   = (state == S_MEET);
    ctl.out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_LAYER) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (stat.item_cmd == CMD_RESOLVE) ? S_MEET : S_OUT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_MEET;
        end
      end
      S_MEET: state_next = S_OUT;
      S_OUT: begin
        if (ctl.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crs_dp #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire crs_pkg::ctl_t                  ctl,
  output crs_pkg::stat_t                      stat,
  input  wire logic                           cfg_wr,
  input  wire logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0]          cfg_data,
  input  wire logic [crs_pkg::CMD_W-1:0]      cmd,
  input  wire logic signed [COORD_BITS-1:0]   rect_left,
  input  wire logic signed [COORD_BITS-1:0]   rect_top,
  input  wire logic signed [COORD_BITS-1:0]   rect_right,
  input  wire logic signed [COORD_BITS-1:0]   rect_bottom,
  input  wire logic [crs_pkg::LAYER_W-1:0]    layer_id,
  output logic signed [COORD_BITS-1:0]        bounds_left,
  output logic signed [COORD_BITS-1:0]        bounds_top,
  output logic signed [COORD_BITS-1:0]        bounds_right,
  output logic signed [COORD_BITS-1:0]        bounds_bottom,
  output logic signed [COORD_BITS-1:0]        clip_left,
  output logic signed [COORD_BITS-1:0]        clip_top,
  output logic signed [COORD_BITS-1:0]        clip_right,
  output logic signed [COORD_BITS-1:0]        clip_bottom,
  output logic [crs_pkg::DEPTH_W-1:0]         clip_depth,
  output logic [crs_pkg::STATUS_W-1:0]        status
);
  import crs_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RW = 4 * COORD_BITS;
  localparam int EW = RW + LAYER_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] l;
    logic signed [COORD_BITS-1:0] t;
    logic signed [COORD_BITS-1:0] r;
    logic signed [COORD_BITS-1:0] b;
  } rect_t;

  function automatic logic is_empty(rect_t a);
    is_empty = ($signed(a.r) <= $signed(a.l)) || ($signed(a.b) <= $signed(a.t));
  endfunction

  function automatic rect_t meet(rect_t a, rect_t b);
    rect_t o;
    if (is_empty(a)) begin
      o = b;
    end else if (is_empty(b)) begin
      o = a;
    end else begin
      o.l = ($signed(a.l) > $signed(b.l)) ? a.l : b.l;
      o.t = ($signed(a.t) > $signed(b.t)) ? a.t : b.t;
      o.r = ($signed(a.r) < $signed(b.r)) ? a.r : b.r;
      o.b = ($signed(a.b) < $signed(b.b)) ? a.b : b.b;
      if ($signed(o.r) < $signed(o.l)) begin
        o.r = o.l;
      end
      if ($signed(o.b) < $signed(o.t)) begin
        o.b = o.t;
      end
    end
    meet = o;
  endfunction

  rect_t                root;
  rect_t                q;
  logic [LAYER_W-1:0]   q_layer;
  logic [CMD_W-1:0]     item_cmd;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic                 pend;
  rect_t                clip_r;
  rect_t                fin_r;
  logic [CW-1:0]        dep_r;
  logic [STATUS_W-1:0]  st_r;

  logic [CW-1:0]        cnt_m1;
  logic                 full;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 ram_we;
  rect_t                ram_rect;
  logic [LAYER_W-1:0]   ram_layer;
  rect_t                top_rect;
  rect_t                push_rect;
  logic [STATUS_W-1:0]  res_status;
  logic                 is_query;

  assign cnt_m1    = count - 1'b1;
  assign full      = (count == FULL_COUNT);
  assign rd_addr   = ctl.scan_run ? idx[AW-1:0] : cnt_m1[AW-1:0];
  assign ram_rect  = rect_t'(rd_data[RW-1:0]);
  assign ram_layer = rd_data[EW-1 -: LAYER_W];
  assign top_rect  = (count == '0) ? root : ram_rect;
  assign push_rect = is_empty(q) ? root : meet(q, top_rect);
  assign ram_we    = ctl.exec_op && (item_cmd == CMD_PUSH) && !full;
  assign is_query  = (item_cmd == CMD_RESOLVE) || (item_cmd == CMD_LAYER);

  assign stat.item_cmd  = item_cmd;
  assign stat.scan_done = (idx == count) && !pend;

  always_comb begin
    if (is_empty(q) || is_empty(fin_r)) begin
      res_status = ST_CULLED;
    end else if (fin_r != q) begin
      res_status = ST_CLIPPED;
    end else begin
      res_status = ST_VISIBLE;
    end
  end

  crs_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({q_layer, push_rect}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // root clip registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root.l <= COORD_BITS'(ROOT_LEFT_RST);
      root.t <= COORD_BITS'(ROOT_TOP_RST);
      root.r <= COORD_BITS'(ROOT_RIGHT_RST);
      root.b <= COORD_BITS'(ROOT_BOTTOM_RST);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ROOT_LEFT:   root.l <= cfg_data;
        REG_ROOT_TOP:    root.t <= cfg_data;
        REG_ROOT_RIGHT:  root.r <= cfg_data;
        REG_ROOT_BOTTOM: root.b <= cfg_data;
        default: ;
      endcase
    end
  end

  // stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      if (ctl.take_item) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (ctl.scan_run) begin
        if (idx < count) begin
          idx  <= idx + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (ctl.exec_op) begin
        unique case (item_cmd)
          CMD_PUSH:  if (!full) count <= count + 1'b1;
          CMD_POP:   if (count != '0) count <= cnt_m1;
          CMD_CLEAR: count <= '0;
          default: ;
        endcase
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      q.l      <= rect_left;
      q.t      <= rect_top;
      q.r      <= rect_right;
      q.b      <= rect_bottom;
      q_layer  <= layer_id;
      item_cmd <= cmd;
      clip_r   <= root;
      dep_r    <= '0;
      st_r     <= ST_DONE;
    end
    if (ctl.scan_run && pend && (ram_layer <= q_layer)) begin
      clip_r <= meet(clip_r, ram_rect);
      dep_r  <= dep_r + 1'b1;
    end
    if (ctl.exec_op) begin
      fin_r <= '0;
      unique case (item_cmd)
        CMD_RESOLVE: begin
          clip_r <= top_rect;
          dep_r  <= count;
        end
        CMD_PUSH: begin
          clip_r <= '0;
          if (full) begin
            dep_r <= count;
            st_r  <= ST_OVERFLOW;
          end else begin
            dep_r <= count + 1'b1;
          end
        end
        CMD_POP: begin
          clip_r <= '0;
          dep_r  <= (count != '0) ? cnt_m1 : count;
        end
        CMD_CLEAR: begin
          clip_r <= '0;
          dep_r  <= '0;
        end
        default: begin
          clip_r <= '0;
          dep_r  <= count;
        end
      endcase
    end
    if (ctl.meet_op) begin
      fin_r <= meet(q, clip_r);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      bounds_left   <= fin_r.l;
      bounds_top    <= fin_r.t;
      bounds_right  <= fin_r.r;
      bounds_bottom <= fin_r.b;
      clip_left     <= clip_r.l;
      clip_top      <= clip_r.t;
      clip_right    <= clip_r.r;
      clip_bottom   <= clip_r.b;
      clip_depth    <= DEPTH_W'(dep_r);
      status        <= is_query ? res_status : st_r;
    end
  end

endmodule

`default_nettype wire
